// ===== rtl/core/slh_pkg.sv =====
// ----------------------------------------------------------------------------
// Symbol lookup package
// Sizes, character codes, state and opcode types, and the name normalizing
// and hashing functions shared by the symbol lookup block.
// ----------------------------------------------------------------------------
package slh_pkg;

   localparam int NAME_BYTES  = 8;
   localparam int BUCKETS     = 128;
   localparam int MAX_ENTRIES = 1024;

   localparam int KEY_W     = 64;
   localparam int OUT_IDX_W = 10;
   localparam int HEADS     = 2 * BUCKETS;
   localparam int HEAD_W    = $clog2(HEADS);
   localparam int IDX_W     = $clog2(MAX_ENTRIES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int SUM_W     = $clog2(NAME_BYTES * 255 + 1);

   localparam logic [7:0] DOT_CHAR    = 8'h2E;
   localparam logic [7:0] TILDE_CHAR  = 8'h7E;
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] UPPER_Z     = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } opcode_type;

   typedef enum logic {
      TBL_SYMBOL = 1'b0,
      TBL_OPCODE = 1'b1
   } table_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_FETCH,
      ST_CMP,
      ST_FINISH
   } slh_state_type;

   // Write side of the entry store.
   typedef struct packed {
      logic             name_we;
      logic [IDX_W-1:0] name_addr;
      logic [KEY_W-1:0] name_data;
      logic             next_we;
      logic [IDX_W-1:0] next_addr;
      logic [IDX_W-1:0] next_data;
   } slh_store_wr_type;

   // Opcode-table names lose a leading dot and are lowered. Bytes beyond
   // NAME_BYTES always come out as zero.
   function automatic logic [KEY_W-1:0] normalize_name(input logic [KEY_W-1:0] key,
                                                       input logic sel);
      logic             strip;
      logic [7:0]       b;
      logic [KEY_W-1:0] res;
      int               src;
      strip = (sel == TBL_OPCODE) && (key[7:0] == DOT_CHAR);
      res   = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         src = strip ? i + 1 : i;
         if (src < NAME_BYTES) begin
            b = key[8*src +: 8];
         end else begin
            b = '0;
         end
         if ((sel == TBL_OPCODE) && (b inside {[UPPER_A:UPPER_Z]})) begin
            b = b + CASE_OFFSET;
         end
         res[8*i +: 8] = b;
      end
      return res;
   endfunction

   // Byte sum masked to the bucket count, offset into the opcode half.
   function automatic logic [HEAD_W-1:0] bucket_head(input logic [KEY_W-1:0] name,
                                                     input logic sel);
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] masked;
      sum = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         sum = sum + SUM_W'(name[8*i +: 8]);
      end
      masked = sum & SUM_W'(BUCKETS - 1);
      return HEAD_W'(masked) + ((sel == TBL_OPCODE) ? HEAD_W'(BUCKETS) : HEAD_W'(0));
   endfunction

   // A '~' name not followed by '~' or '.' never matches.
   function automatic logic is_local_name(input logic [KEY_W-1:0] name);
      return (name[7:0] == TILDE_CHAR) && (name[15:8] != TILDE_CHAR) &&
             (name[15:8] != DOT_CHAR);
   endfunction

endpackage

// ===== rtl/core/slh_if.sv =====
// ----------------------------------------------------------------------------
// Symbol lookup channels
// Valid/ready channels for lookup requests and lookup responses.
// ----------------------------------------------------------------------------
interface slh_req_if;
   import slh_pkg::*;
   logic             valid;
   logic             ready;
   logic             opcode;
   logic             table_select;
   logic [KEY_W-1:0] name_key;

   modport source (output valid, opcode, table_select, name_key, input ready);
   modport sink   (input valid, opcode, table_select, name_key, output ready);
endinterface

interface slh_rsp_if;
   import slh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [OUT_IDX_W-1:0] entry_index;
   logic                 table_full;

   modport source (output valid, found, entry_index, table_full, input ready);
   modport sink   (input valid, found, entry_index, table_full, output ready);
endinterface

// ===== rtl/core/hash_chained_symbol_lookup.sv =====
// ----------------------------------------------------------------------------
// Hash chained symbol lookup
// Looks an 8-byte name up in the symbol or opcode hash table and appends it
// on request; both tables share one entry store with chained buckets.
// ----------------------------------------------------------------------------
// Usage. A request word on req_bus carries the opcode (lookup, or lookup and
// insert when absent), the table select and the zero-padded name. The block
// takes one request at a time: req_bus.ready is high only while the lookup
// sequencer is idle. Each request yields exactly one response word on
// rsp_bus with found, the entry index and the table-full flag.
// Sequence. After the accepting edge the request normalizes and hashes the
// name, reads the bucket head, then makes one fetch and compares each chain
// entry in turn through the single name comparator, and ends in a finish
// step that loads the response register and performs any insert. An empty
// bucket or a local name skips the fetch and the compares. The chain walk,
// one entry-store read per step, sets the rate.
// Stalls. The response sits in an output register; while it is not taken
// the block still accepts and works on the next request and holds it in
// the finish cycle until the register is free.
// Reset. Synchronous reset empties every bucket and the entry store count.
// No memory clearing pass is needed; the bucket valid bits cover it.
// ----------------------------------------------------------------------------
module hash_chained_symbol_lookup (
   input logic      clock,
   input logic      reset,
   slh_req_if.sink   req_bus,
   slh_rsp_if.source rsp_bus
);
   import slh_pkg::*;

   slh_state_type    state_ff, state_in;

   // Request captured at accept time.
   logic             op_ff;
   logic             sel_ff;
   logic [KEY_W-1:0] key_ff;

   // Normalized name and its bucket.
   logic [KEY_W-1:0]  name_ff;
   logic [HEAD_W-1:0] head_ff;
   logic              local_ff;

   // Bucket heads: valid bits in flops, first and last links in memories.
   logic [HEADS-1:0] bucket_valid_ff;
   logic [IDX_W-1:0] bucket_first_mem [HEADS];
   logic [IDX_W-1:0] bucket_last_mem [HEADS];
   logic [IDX_W-1:0] first_rd_ff;
   logic [IDX_W-1:0] last_rd_ff;

   // Chain walk.
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             found_ff;
   logic [KEY_W-1:0] entry_rd_name;
   logic [IDX_W-1:0] entry_rd_next;
   logic             name_match;
   logic             at_last;

   logic [CNT_W-1:0] entry_count_ff;

   // Response register.
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_full_ff;

   // Sequencer outputs.
   logic             req_ready;
   logic             finish_go;
   logic             out_free;

   logic             store_full;
   logic             do_insert;
   logic [IDX_W-1:0] new_idx;
   slh_store_wr_type store_wr;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign name_match = (entry_rd_name == name_ff);
   assign at_last    = (cur_ff == last_rd_ff);
   assign store_full = (entry_count_ff == CNT_W'(MAX_ENTRIES));
   assign new_idx    = entry_count_ff[IDX_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (local_ff || !bucket_valid_ff[head_ff]) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (name_match || at_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs. The entry address read each cycle is the next
   // value of the walk pointer, so the compare cycle always sees the data
   // of the entry the pointer names.
   always_comb begin
      req_ready = 1'b0;
      finish_go = 1'b0;
      cur_in    = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_FETCH: begin
            cur_in = first_rd_ff;
         end
         ST_CMP: begin
            if (!name_match && !at_last) begin
               cur_in = entry_rd_next;
            end
         end
         ST_FINISH: begin
            finish_go = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_bus.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture and the hash stage.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_ready) begin
         op_ff  <= req_bus.opcode;
         sel_ff <= req_bus.table_select;
         key_ff <= req_bus.name_key;
      end
      if (state_ff == ST_HASH) begin
         name_ff  <= normalize_name(key_ff, sel_ff);
         head_ff  <= bucket_head(normalize_name(key_ff, sel_ff), sel_ff);
         local_ff <= is_local_name(normalize_name(key_ff, sel_ff));
      end
   end

   // Walk pointer and match flag.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (state_ff == ST_HASH) begin
         found_ff <= 1'b0;
      end else if ((state_ff == ST_CMP) && name_match) begin
         found_ff <= 1'b1;
      end
   end

   // An insert happens in the cycle that leaves the finish state.
   assign do_insert = finish_go && !found_ff && !store_full && (op_ff == OP_INSERT);

   always_ff @(posedge clock) begin
      if (do_insert && !bucket_valid_ff[head_ff]) begin
         bucket_first_mem[head_ff] <= new_idx;
      end
      first_rd_ff <= bucket_first_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (do_insert) begin
         bucket_last_mem[head_ff] <= new_idx;
      end
      last_rd_ff <= bucket_last_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_valid_ff <= '0;
         entry_count_ff  <= '0;
      end else if (do_insert) begin
         bucket_valid_ff[head_ff] <= 1'b1;
         entry_count_ff           <= entry_count_ff + CNT_W'(1);
      end
   end

   // The new entry takes the next free index and is linked behind the
   // bucket's current last entry when the bucket already has a chain.
   always_comb begin
      store_wr.name_we   = do_insert;
      store_wr.name_addr = new_idx;
      store_wr.name_data = name_ff;
      store_wr.next_we   = do_insert && bucket_valid_ff[head_ff];
      store_wr.next_addr = last_rd_ff;
      store_wr.next_data = new_idx;
   end

   slh_entry_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (cur_in),
      .rd_name (entry_rd_name),
      .rd_next (entry_rd_next)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_found_ff <= found_ff;
         if (found_ff) begin
            rsp_idx_ff  <= cur_ff;
            rsp_full_ff <= 1'b0;
         end else if (store_full) begin
            rsp_idx_ff  <= '0;
            rsp_full_ff <= (op_ff == OP_INSERT);
         end else begin
            rsp_idx_ff  <= new_idx;
            rsp_full_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.entry_index = OUT_IDX_W'(rsp_idx_ff);
   assign rsp_bus.table_full  = rsp_full_ff;

   // The entry count never passes the store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond store size");

   // A chain walk only visits entries that have been written.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (CNT_W'(cur_ff) < entry_count_ff))
      else $error("chain walk left the written entries");

   // A found entry is one that exists.
   a_found_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (CNT_W'(rsp_idx_ff) < entry_count_ff))
      else $error("found index beyond entry count");

   // Table full only for an absent name with the store full.
   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |->
         (!rsp_found_ff && (rsp_idx_ff == '0) && store_full))
      else $error("table full response inconsistent");

   // Entries are added only when a request finishes.
   a_count_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(entry_count_ff)) |-> $past(state_ff == ST_FINISH))
      else $error("entry count changed outside the finish cycle");

endmodule

// ===== rtl/core/slh_entry_store.sv =====
// ----------------------------------------------------------------------------
// Symbol lookup entry store
// Name and chain-link memories of all entries, one write port each and a
// registered read at a shared address.
// ----------------------------------------------------------------------------
module slh_entry_store (
   input  logic                            clock,
   input  slh_pkg::slh_store_wr_type       wr,
   input  logic [slh_pkg::IDX_W-1:0]       rd_addr,
   output logic [slh_pkg::KEY_W-1:0]       rd_name,
   output logic [slh_pkg::IDX_W-1:0]       rd_next
);
   import slh_pkg::*;

   logic [KEY_W-1:0] name_mem [MAX_ENTRIES];
   logic [IDX_W-1:0] next_mem [MAX_ENTRIES];
   logic [KEY_W-1:0] rd_name_ff;
   logic [IDX_W-1:0] rd_next_ff;

   always_ff @(posedge clock) begin
      if (wr.name_we) begin
         name_mem[wr.name_addr] <= wr.name_data;
      end
      rd_name_ff <= name_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_data;
      end
      rd_next_ff <= next_mem[rd_addr];
   end

   assign rd_name = rd_name_ff;
   assign rd_next = rd_next_ff;

endmodule
